/* rtl/mbce_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monochrome color expansion package
// Register indexes, the configuration register bundle and the size clamp
// shared by the color expansion blit modules.
// ----------------------------------------------------------------------------
package mbce_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_FG_COLOR = 3'd0,
		REG_BG_COLOR = 3'd1,
		REG_CLIP_X   = 3'd2,
		REG_CLIP_Y   = 3'd3,
		REG_CLIP_W   = 3'd4,
		REG_CLIP_H   = 3'd5,
		REG_FB_WIDTH = 3'd6
	} reg_index_t;

	localparam int IdxW   = 3;
	localparam int DataW  = 24;
	localparam int ColorW = 24;
	localparam int PosW   = 12;
	localparam int DimW   = 13;
	localparam int AddrW  = 26;

	localparam logic [ColorW-1:0] FgColorRst = 24'hFFFFFF;
	localparam logic [ColorW-1:0] BgColorRst = 24'h000000;
	localparam logic [DimW-1:0]   ClipWRst   = 13'd1024;
	localparam logic [DimW-1:0]   ClipHRst   = 13'd768;
	localparam logic [DimW-1:0]   FbWidthRst = 13'd1024;

	// Operation codes of a command beat.
	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	// Live configuration handed from the register file to the engine.
	typedef struct packed {
		logic [ColorW-1:0] fg_color;
		logic [ColorW-1:0] bg_color;
		logic [PosW-1:0]   clip_x;
		logic [PosW-1:0]   clip_y;
		logic [DimW-1:0]   clip_w;
		logic [DimW-1:0]   clip_h;
		logic [DimW-1:0]   fb_width;
	} cfg_regs_t;

	// Clamp a requested size to the room left in the window, then to the limit.
	function automatic logic [DimW-1:0] clamp_size(
		input logic [DimW-1:0] win,
		input logic [PosW-1:0] pos,
		input logic [DimW-1:0] req,
		input logic [DimW:0]   lim
	);
		logic [DimW-1:0] room;
		logic [DimW-1:0] s;
		room = ({1'b0, pos} >= win) ? '0 : (win - {1'b0, pos});
		s = (req < room) ? req : room;
		if ({1'b0, s} > lim) begin
			s = lim[DimW-1:0];
		end
		return s;
	endfunction

endpackage

/* rtl/mbce_cmd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel interface
// Carries start and pattern data beats into the blit.
// ----------------------------------------------------------------------------
interface mbce_cmd_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [12:0] bmp_width;
	logic [12:0] bmp_height;
	logic [7:0]  pattern_byte;

	modport source (output valid, op, pos_x, pos_y, bmp_width, bmp_height, pattern_byte,
		input ready);
	modport sink (input valid, op, pos_x, pos_y, bmp_width, bmp_height, pattern_byte,
		output ready);
endinterface

/* rtl/mbce_pix_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel channel interface
// Carries one framebuffer pixel write per beat.
// ----------------------------------------------------------------------------
interface mbce_pix_if;
	logic        valid;
	logic        ready;
	logic [25:0] byte_address;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        last_pixel;

	modport source (output valid, byte_address, red, green, blue, last_pixel, input ready);
	modport sink (input valid, byte_address, red, green, blue, last_pixel, output ready);
endinterface

/* rtl/mbce_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write interface
// Carries one register write per beat.
// ----------------------------------------------------------------------------
interface mbce_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [mbce_pkg::IdxW-1:0]  index;
	logic [mbce_pkg::DataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/mono_bitmap_color_expand.sv */
`timescale 1ns / 1ps
// Each pixel is registered in the output stage. Pixels issue one per cycle unless the
// pixel port stalls; a data beat holds the engine for its eight pixels, fewer at the
// bitmap end, and the next beat is taken in the cycle its last pixel issues. A start
// beat holds off commands for the row base multiply; a beat with no bitmap open issues
// no pixels. Reset is asynchronous, active low, and leaves no bitmap open.
// ----------------------------------------------------------------------------
// Monochrome bitmap color expansion blit
// Expands one-bit-per-pixel pattern bytes into clipped RGB framebuffer writes.
// ----------------------------------------------------------------------------
module mono_bitmap_color_expand #(
	parameter int MAX_DIM = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	mbce_cfg_if.sink   cfg,
	mbce_cmd_if.sink   cmd,
	mbce_pix_if.source pix
);

	mbce_pkg::cfg_regs_t regs;

	// Configuration registers.
	mbce_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Bitmap walk and pixel expansion.
	mbce_engine #(
		.MAX_DIM (MAX_DIM)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.cmd    (cmd),
		.pix    (pix)
	);

endmodule

/* rtl/mbce_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration register file
// Holds colors, clip window and framebuffer line length.
// ----------------------------------------------------------------------------
module mbce_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	mbce_cfg_if.sink              cfg,
	output mbce_pkg::cfg_regs_t   regs
);

	mbce_pkg::cfg_regs_t regs_q;

	// Writes are always taken.
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.fg_color <= mbce_pkg::FgColorRst;
			regs_q.bg_color <= mbce_pkg::BgColorRst;
			regs_q.clip_x   <= '0;
			regs_q.clip_y   <= '0;
			regs_q.clip_w   <= mbce_pkg::ClipWRst;
			regs_q.clip_h   <= mbce_pkg::ClipHRst;
			regs_q.fb_width <= mbce_pkg::FbWidthRst;
		end else if (cfg.valid) begin
			case (cfg.index)
				mbce_pkg::REG_FG_COLOR: regs_q.fg_color <= cfg.data;
				mbce_pkg::REG_BG_COLOR: regs_q.bg_color <= cfg.data;
				mbce_pkg::REG_CLIP_X:   regs_q.clip_x   <= cfg.data[mbce_pkg::PosW-1:0];
				mbce_pkg::REG_CLIP_Y:   regs_q.clip_y   <= cfg.data[mbce_pkg::PosW-1:0];
				mbce_pkg::REG_CLIP_W:   regs_q.clip_w   <= cfg.data[mbce_pkg::DimW-1:0];
				mbce_pkg::REG_CLIP_H:   regs_q.clip_h   <= cfg.data[mbce_pkg::DimW-1:0];
				mbce_pkg::REG_FB_WIDTH: regs_q.fb_width <= cfg.data[mbce_pkg::DimW-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/mbce_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel expansion engine
// Tracks the bitmap walk and turns each pattern byte into pixel beats,
// one per cycle unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module mbce_engine #(
	parameter int MAX_DIM = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mbce_pkg::cfg_regs_t regs,
	mbce_cmd_if.sink            cmd,
	mbce_pix_if.source          pix
);

	localparam int DimW  = mbce_pkg::DimW;
	localparam int AddrW = mbce_pkg::AddrW;
	localparam logic [DimW:0] MaxDim = (DimW + 1)'(MAX_DIM);

	// Bitmap walk state.
	logic [DimW-1:0]  origin_x_q, origin_y_q, eff_w_q, eff_h_q, col_q, row_q;
	logic             active_q, base_pend_q;
	logic [AddrW-1:0] row_base_q, cur_q;

	// Pattern byte being expanded.
	logic             busy_q;
	logic [7:0]       pat_q;
	logic [2:0]       bit_q;

	// Output stage.
	logic             out_valid_q, last_q;
	logic [AddrW-1:0] addr_q;
	logic [23:0]      color_q;

	logic             out_free, emit, drop, eng_done;
	logic             accept, start, data;
	logic [DimW:0]    col_nxt, row_nxt;
	logic             wrap, fin;
	logic [AddrW-1:0] base_calc, next_base;

	// Pixel issue control.
	assign out_free = !out_valid_q || pix.ready;
	assign emit     = busy_q && active_q && out_free;
	assign drop     = busy_q && !active_q;
	assign col_nxt  = {1'b0, col_q} + 1'b1;
	assign row_nxt  = {1'b0, row_q} + 1'b1;
	assign wrap     = col_nxt >= {1'b0, eff_w_q};
	assign fin      = wrap && (row_nxt >= {1'b0, eff_h_q});
	assign eng_done = drop || (emit && ((bit_q == 3'd7) || fin));

	// Command acceptance.
	assign cmd.ready = !base_pend_q && (!busy_q || eng_done);
	assign accept    = cmd.valid && cmd.ready;
	assign start     = accept && (cmd.op == mbce_pkg::OP_START);
	assign data      = accept && (cmd.op == mbce_pkg::OP_DATA);

	// Pixel index of the bitmap origin, and of the next row start.
	assign base_calc = AddrW'(regs.fb_width) * AddrW'(origin_y_q)
		+ {{(AddrW - DimW){1'b0}}, origin_x_q};
	assign next_base = row_base_q + {{(AddrW - DimW){1'b0}}, regs.fb_width};

	// Bitmap walk: a start beat loads it, the following cycle forms the base
	// pixel index, and each issued pixel advances it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			eff_w_q     <= '0;
			eff_h_q     <= '0;
			col_q       <= '0;
			row_q       <= '0;
			active_q    <= 1'b0;
			base_pend_q <= 1'b0;
			row_base_q  <= '0;
			cur_q       <= '0;
		end else if (start) begin
			origin_x_q  <= DimW'({1'b0, regs.clip_x} + {1'b0, cmd.pos_x});
			origin_y_q  <= DimW'({1'b0, regs.clip_y} + {1'b0, cmd.pos_y});
			eff_w_q     <= mbce_pkg::clamp_size(regs.clip_w, cmd.pos_x, cmd.bmp_width, MaxDim);
			eff_h_q     <= mbce_pkg::clamp_size(regs.clip_h, cmd.pos_y, cmd.bmp_height, MaxDim);
			active_q    <= (mbce_pkg::clamp_size(regs.clip_w, cmd.pos_x, cmd.bmp_width,
				MaxDim) != '0) && (mbce_pkg::clamp_size(regs.clip_h, cmd.pos_y,
				cmd.bmp_height, MaxDim) != '0);
			col_q       <= '0;
			row_q       <= '0;
			base_pend_q <= 1'b1;
		end else if (base_pend_q) begin
			row_base_q  <= base_calc;
			cur_q       <= base_calc;
			base_pend_q <= 1'b0;
		end else if (emit) begin
			if (wrap) begin
				col_q      <= '0;
				row_q      <= row_nxt[DimW-1:0];
				row_base_q <= next_base;
				cur_q      <= next_base;
				if (fin) begin
					active_q <= 1'b0;
				end
			end else begin
				col_q <= col_nxt[DimW-1:0];
				cur_q <= cur_q + 1'b1;
			end
		end
	end

	// Pattern byte holder, shifted out MSB first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pat_q  <= '0;
			bit_q  <= '0;
		end else if (data) begin
			busy_q <= 1'b1;
			pat_q  <= cmd.pattern_byte;
			bit_q  <= '0;
		end else if (eng_done) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			pat_q <= {pat_q[6:0], 1'b0};
			bit_q <= bit_q + 1'b1;
		end
	end

	// Output stage: three bytes per pixel, color chosen by the pattern bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			addr_q  <= {cur_q[AddrW-2:0], 1'b0} + cur_q;
			color_q <= pat_q[7] ? regs.fg_color : regs.bg_color;
			last_q  <= fin;
		end
	end

	assign pix.valid        = out_valid_q;
	assign pix.byte_address = addr_q;
	assign pix.red          = color_q[23:16];
	assign pix.green        = color_q[15:8];
	assign pix.blue         = color_q[7:0];
	assign pix.last_pixel   = last_q;

endmodule

/* rtl/mbce_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit port checker
// Watches the top level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module mbce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_ready,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        cmd_op,
	input logic        pix_valid,
	input logic        pix_ready,
	input logic [25:0] pix_byte_address,
	input logic        pix_last_pixel
);

	// A stalled pixel beat keeps its address and last flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix_byte_address)
			&& $stable(pix_last_pixel))
		else $error("pixel beat changed while stalled");

	// A pixel beat leaves only after it was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pix_valid) |-> $past(pix_ready))
		else $error("pixel beat dropped without handshake");

	// No command is taken in the cycle after a start beat, during row base setup.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_op == mbce_pkg::OP_START) |=> !cmd_ready)
		else $error("command taken during row base setup");

	// Register writes are never held off.
	assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind mono_bitmap_color_expand mbce_checker u_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cfg_ready        (cfg.ready),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.cmd_op           (cmd.op),
	.pix_valid        (pix.valid),
	.pix_ready        (pix.ready),
	.pix_byte_address (pix.byte_address),
	.pix_last_pixel   (pix.last_pixel)
);
